@@ rtl/delta_list_timer_manager_assert.svh @@
// assertion macros used by the timer manager back end
`ifndef DELTA_LIST_TIMER_MANAGER_ASSERT_SVH
`define DELTA_LIST_TIMER_MANAGER_ASSERT_SVH
`ifndef SYNTH
// property holds at every clock edge outside reset
`define DLTM_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("delta list timer manager: assertion failed");
// consequent holds in the cycle after the antecedent
`define DLTM_ASSERT_NEXT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("delta list timer manager: assertion failed");
`else
`define DLTM_ASSERT(lbl, ck, rs, prop)
`define DLTM_ASSERT_NEXT(lbl, ck, rs, pre, post)
`endif
`endif

@@ rtl/dltm_pkg.sv @@
package dltm_pkg;

  localparam int TIMER_SLOTS = 64;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int ID_W        = 16;
  localparam int OWNER_W     = 16;
  localparam int DELTA_W     = 31;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_STOP   = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND   = 2'd2;
  localparam logic [1:0] ST_FULL        = 2'd3;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;

  localparam logic ONE_SHOT = 1'b1;

  typedef struct packed {
    logic [2:0]         op;
    logic [OWNER_W-1:0] owner;
    logic [ID_W-1:0]    handle;
    logic [DELTA_W-1:0] period;
    logic               single;
    logic               bad;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]    ident;
    logic [OWNER_W-1:0] owner;
    logic [DELTA_W-1:0] period;
    logic               single;
  } slot_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [DELTA_W-1:0] delta;
  } list_word_t;

endpackage

@@ rtl/dltm_ram.sv @@
module dltm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dltm_front.sv @@
module dltm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          op,
  input  logic [15:0]         owner,
  input  logic [15:0]         handle,
  input  logic signed [31:0]  period,
  input  logic                one_shot,
  input  logic                pop,
  output logic                q_valid,
  output dltm_pkg::cmd_t      q_cmd
);

  dltm_pkg::cmd_t queue [dltm_pkg::QDEPTH];
  dltm_pkg::cmd_t entry;
  logic [dltm_pkg::QPTR_W-1:0] wr_ptr;
  logic [dltm_pkg::QPTR_W-1:0] rd_ptr;
  logic [dltm_pkg::QCNT_W-1:0] fill;
  logic accept;
  logic push;
  logic take;

  localparam int QCW = dltm_pkg::QCNT_W;

  assign busy    = (fill == QCW'(dltm_pkg::QDEPTH));
  assign q_valid = (fill != '0);
  assign q_cmd   = queue[rd_ptr];
  assign accept  = start && !busy;
  // unknown opcodes are dropped here
  assign push    = accept && (op <= dltm_pkg::OP_TICK);
  assign take    = pop && q_valid;

  always_comb begin
    entry.op     = op;
    entry.owner  = owner;
    entry.handle = handle;
    entry.period = period[30:0];
    entry.single = (one_shot == dltm_pkg::ONE_SHOT);
    entry.bad    = period[31] || (period == '0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !take) begin
        fill <= fill + 1'b1;
      end else if (!push && take) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ rtl/dltm_back.sv @@
`include "delta_list_timer_manager_assert.svh"

module dltm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  dltm_pkg::cmd_t q_cmd,
  output logic           pop,
  output logic           strobe,
  output logic           kind,
  output logic [1:0]     status,
  output logic [15:0]    result_id,
  output logic [15:0]    result_owner,
  output logic           last
);

  localparam int N  = dltm_pkg::TIMER_SLOTS;
  localparam int SW = dltm_pkg::SLOT_W;
  localparam int CW = dltm_pkg::CNT_W;
  localparam int DW = dltm_pkg::DELTA_W;
  localparam logic [CW-1:0] SLOTS = CW'(N);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FREE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_RFIND = 4'd3;
  localparam logic [3:0] S_SHDN  = 4'd4;
  localparam logic [3:0] S_IRD   = 4'd5;
  localparam logic [3:0] S_ICMP  = 4'd6;
  localparam logic [3:0] S_SHUP  = 4'd7;
  localparam logic [3:0] S_IPUT  = 4'd8;
  localparam logic [3:0] S_RET   = 4'd9;
  localparam logic [3:0] S_THEAD = 4'd10;
  localparam logic [3:0] S_EMRD  = 4'd11;
  localparam logic [3:0] S_EMSR  = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  localparam logic [1:0] RET_REPLY = 2'd0;
  localparam logic [1:0] RET_TDROP = 2'd1;
  localparam logic [1:0] RET_TNEXT = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [15:0] id;
    logic [15:0] owner;
    logic        last;
  } res_t;

  function automatic res_t reply(input logic [1:0] st, input logic [15:0] id);
    res_t r;
    r.kind   = dltm_pkg::KIND_REPLY;
    r.status = st;
    r.id     = id;
    r.owner  = '0;
    r.last   = 1'b1;
    return r;
  endfunction

  logic [3:0]     state;
  dltm_pkg::cmd_t cmd;
  logic [N-1:0]   slot_used;
  logic [N-1:0]   slot_running;
  logic [CW-1:0]  list_count;
  logic [15:0]    id_counter;
  logic [CW-1:0]  scan;
  logic [CW-1:0]  pos;
  logic [CW-1:0]  rj;
  logic [CW-1:0]  wptr;
  logic [CW-1:0]  n_due;
  logic [CW-1:0]  i_due;
  logic           chk;
  logic           tfirst;
  logic [SW-1:0]  pidx;
  logic [SW-1:0]  sel;
  logic [DW-1:0]  rem;
  logic [DW-1:0]  ins_delta;
  logic [DW-1:0]  add;
  logic [1:0]     ret;
  res_t           res;

  logic                   sr_we;
  logic [SW-1:0]          sr_waddr;
  logic [SW-1:0]          sr_raddr;
  dltm_pkg::slot_word_t   sr_wdata;
  dltm_pkg::slot_word_t   sr_rdata;
  logic                   lr_we;
  logic [SW-1:0]          lr_waddr;
  logic [SW-1:0]          lr_raddr;
  dltm_pkg::list_word_t   lr_wdata;
  dltm_pkg::list_word_t   lr_rdata;
  logic                   du_we;
  logic [SW-1:0]          du_waddr;
  logic [SW-1:0]          du_raddr;
  logic [SW-1:0]          du_wdata;
  logic [SW-1:0]          du_rdata;

  logic [SW-1:0] scan_idx;
  logic [CW-1:0] rj_m1;
  logic [15:0]   id_next;
  logic          free_hit;
  logic          match_look;
  logic          match_list;
  logic          head_dec;
  logic [DW-1:0] head_delta;
  logic          tick_empty;

  assign scan_idx   = scan[SW-1:0];
  assign rj_m1      = rj - 1'b1;
  assign id_next    = id_counter + 1'b1;
  assign free_hit   = (scan != SLOTS) && !slot_used[scan_idx];
  assign match_look = chk && slot_used[pidx] && (sr_rdata.owner == cmd.owner)
                      && (sr_rdata.ident == cmd.handle);
  assign match_list = chk && (lr_rdata.slot == sel);
  assign head_dec   = tfirst && (lr_rdata.delta != '0);
  assign head_delta = head_dec ? (lr_rdata.delta - 1'b1) : lr_rdata.delta;
  assign pop        = (state == S_IDLE);
  assign tick_empty = (state == S_IDLE) && q_valid && (q_cmd.op == dltm_pkg::OP_TICK)
                      && (list_count == '0);

  assign kind         = res.kind;
  assign status       = res.status;
  assign result_id    = res.id;
  assign result_owner = res.owner;
  assign last         = res.last;

  dltm_ram #(.WIDTH($bits(dltm_pkg::slot_word_t)), .DEPTH(N)) u_slot_ram (
    .clk(clk), .we(sr_we), .waddr(sr_waddr), .wdata(sr_wdata),
    .raddr(sr_raddr), .rdata(sr_rdata)
  );

  dltm_ram #(.WIDTH($bits(dltm_pkg::list_word_t)), .DEPTH(N)) u_list_ram (
    .clk(clk), .we(lr_we), .waddr(lr_waddr), .wdata(lr_wdata),
    .raddr(lr_raddr), .rdata(lr_rdata)
  );

  dltm_ram #(.WIDTH(SW), .DEPTH(N)) u_due_ram (
    .clk(clk), .we(du_we), .waddr(du_waddr), .wdata(du_wdata),
    .raddr(du_raddr), .rdata(du_rdata)
  );

  always_comb begin
    sr_we           = 1'b0;
    sr_waddr        = scan_idx;
    sr_wdata.ident  = id_next;
    sr_wdata.owner  = cmd.owner;
    sr_wdata.period = cmd.period;
    sr_wdata.single = cmd.single;
    sr_raddr        = scan_idx;
    lr_we           = 1'b0;
    lr_waddr        = wptr[SW-1:0];
    lr_wdata        = lr_rdata;
    lr_raddr        = '0;
    du_we           = 1'b0;
    du_waddr        = n_due[SW-1:0];
    du_wdata        = lr_rdata.slot;
    du_raddr        = i_due[SW-1:0];
    unique case (state)
      S_FREE: sr_we = free_hit;
      S_EMSR: sr_raddr = du_rdata;
      S_RFIND: lr_raddr = scan_idx;
      S_SHDN: begin
        lr_we          = chk;
        lr_wdata.delta = lr_rdata.delta + add;
        lr_raddr       = scan_idx;
      end
      S_IRD: lr_raddr = pos[SW-1:0];
      S_SHUP: begin
        lr_we = chk;
        if (wptr == pos + 1'b1) begin
          lr_wdata.delta = ins_delta;
        end
        lr_raddr = rj_m1[SW-1:0];
      end
      S_IPUT: begin
        lr_we          = 1'b1;
        lr_waddr       = pos[SW-1:0];
        lr_wdata.slot  = sel;
        lr_wdata.delta = rem;
      end
      S_THEAD: begin
        lr_we          = head_dec;
        lr_waddr       = '0;
        lr_wdata.delta = head_delta;
        du_we          = (head_delta == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slot_used    <= '0;
      slot_running <= '0;
      list_count   <= '0;
      id_counter   <= '0;
      strobe       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            unique case (q_cmd.op)
              dltm_pkg::OP_CREATE: begin
                if (q_cmd.bad) begin
                  res    <= reply(dltm_pkg::ST_BAD_TIMEOUT, '0);
                  strobe <= 1'b1;
                end else begin
                  scan  <= '0;
                  state <= S_FREE;
                end
              end
              dltm_pkg::OP_DELETE, dltm_pkg::OP_START, dltm_pkg::OP_STOP: begin
                scan  <= '0;
                chk   <= 1'b0;
                state <= S_LOOK;
              end
              default: begin
                if (list_count != '0) begin
                  tfirst <= 1'b1;
                  n_due  <= '0;
                  state  <= S_THEAD;
                end
              end
            endcase
          end
        end
        S_FREE: begin
          if (scan == SLOTS) begin
            res    <= reply(dltm_pkg::ST_FULL, '0);
            strobe <= 1'b1;
            state  <= S_IDLE;
          end else if (free_hit) begin
            slot_used[scan_idx]    <= 1'b1;
            slot_running[scan_idx] <= 1'b0;
            id_counter             <= id_next;
            res                    <= reply(dltm_pkg::ST_OK, id_next);
            strobe                 <= 1'b1;
            state                  <= S_IDLE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_LOOK: begin
          chk  <= (scan < SLOTS);
          pidx <= scan_idx;
          if (scan < SLOTS) begin
            scan <= scan + 1'b1;
          end
          if (match_look) begin
            sel  <= pidx;
            rem  <= sr_rdata.period;
            ret  <= RET_REPLY;
            scan <= '0;
            chk  <= 1'b0;
            pos  <= '0;
            unique case (cmd.op)
              dltm_pkg::OP_DELETE: begin
                slot_used[pidx] <= 1'b0;
                if (slot_running[pidx]) begin
                  state <= S_RFIND;
                end else begin
                  res    <= reply(dltm_pkg::ST_OK, '0);
                  strobe <= 1'b1;
                  state  <= S_IDLE;
                end
              end
              dltm_pkg::OP_START: begin
                if (slot_running[pidx]) begin
                  res    <= reply(dltm_pkg::ST_OK, '0);
                  strobe <= 1'b1;
                  state  <= S_IDLE;
                end else begin
                  state <= S_IRD;
                end
              end
              default: begin
                if (slot_running[pidx]) begin
                  state <= S_RFIND;
                end else begin
                  res    <= reply(dltm_pkg::ST_OK, '0);
                  strobe <= 1'b1;
                  state  <= S_IDLE;
                end
              end
            endcase
          end else if (scan == SLOTS) begin
            res    <= reply(dltm_pkg::ST_NOT_FOUND, '0);
            strobe <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_RFIND: begin
          chk  <= (scan < list_count);
          pidx <= scan_idx;
          if (scan < list_count) begin
            scan <= scan + 1'b1;
          end
          if (match_list) begin
            add                <= lr_rdata.delta;
            scan               <= CW'(pidx) + 1'b1;
            wptr               <= CW'(pidx);
            chk                <= 1'b0;
            slot_running[sel]  <= 1'b0;
            state              <= S_SHDN;
          end else if (scan >= list_count) begin
            slot_running[sel] <= 1'b0;
            state             <= S_RET;
          end
        end
        S_SHDN: begin
          if (chk) begin
            wptr <= wptr + 1'b1;
            add  <= '0;
          end
          if (scan < list_count) begin
            scan <= scan + 1'b1;
            chk  <= 1'b1;
          end else begin
            chk <= 1'b0;
          end
          if (!chk && (scan >= list_count)) begin
            list_count <= list_count - 1'b1;
            state      <= S_RET;
          end
        end
        S_IRD: begin
          if (list_count >= SLOTS) begin
            state <= S_RET;
          end else if (pos < list_count) begin
            state <= S_ICMP;
          end else begin
            state <= S_IPUT;
          end
        end
        S_ICMP: begin
          if (rem >= lr_rdata.delta) begin
            rem   <= rem - lr_rdata.delta;
            pos   <= pos + 1'b1;
            state <= S_IRD;
          end else begin
            ins_delta <= lr_rdata.delta - rem;
            rj        <= list_count;
            wptr      <= list_count;
            chk       <= 1'b0;
            state     <= S_SHUP;
          end
        end
        S_SHUP: begin
          if (chk) begin
            wptr <= wptr - 1'b1;
          end
          if (rj > pos) begin
            rj  <= rj_m1;
            chk <= 1'b1;
          end else begin
            chk <= 1'b0;
          end
          if (!chk && (rj <= pos)) begin
            state <= S_IPUT;
          end
        end
        S_IPUT: begin
          list_count        <= list_count + 1'b1;
          slot_running[sel] <= 1'b1;
          state             <= S_RET;
        end
        S_RET: begin
          unique case (ret)
            RET_REPLY: begin
              res    <= reply(dltm_pkg::ST_OK, '0);
              strobe <= 1'b1;
              state  <= S_IDLE;
            end
            RET_TDROP: begin
              if (list_count == '0) begin
                i_due <= '0;
                state <= S_EMRD;
              end else begin
                state <= S_THEAD;
              end
            end
            default: begin
              i_due <= i_due + 1'b1;
              if (i_due + 1'b1 == n_due) begin
                state <= S_IDLE;
              end else begin
                state <= S_EMRD;
              end
            end
          endcase
        end
        S_THEAD: begin
          tfirst <= 1'b0;
          if (head_delta == '0) begin
            n_due                       <= n_due + 1'b1;
            sel                         <= lr_rdata.slot;
            slot_running[lr_rdata.slot] <= 1'b0;
            scan                        <= CW'(1);
            wptr                        <= '0;
            chk                         <= 1'b0;
            add                         <= '0;
            ret                         <= RET_TDROP;
            state                       <= S_SHDN;
          end else if (n_due == '0) begin
            state <= S_IDLE;
          end else begin
            i_due <= '0;
            state <= S_EMRD;
          end
        end
        S_EMRD: state <= S_EMSR;
        S_EMSR: begin
          sel   <= du_rdata;
          state <= S_EMIT;
        end
        S_EMIT: begin
          res.kind   <= dltm_pkg::KIND_NOTICE;
          res.status <= dltm_pkg::ST_OK;
          res.id     <= sr_rdata.ident;
          res.owner  <= sr_rdata.owner;
          res.last   <= (i_due + 1'b1 == n_due);
          strobe     <= 1'b1;
          ret        <= RET_TNEXT;
          rem        <= sr_rdata.period;
          pos        <= '0;
          if (sr_rdata.single) begin
            state <= S_RET;
          end else begin
            state <= S_IRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DLTM_ASSERT(a_running_listed, clk, rst, $countones(slot_running) <= list_count)
  `DLTM_ASSERT_NEXT(a_notice_gap, clk, rst, strobe && (kind == dltm_pkg::KIND_NOTICE), !strobe)
  `DLTM_ASSERT_NEXT(a_empty_tick, clk, rst, tick_empty, !strobe)

endmodule

@@ rtl/delta_list_timer_manager.sv @@
// delta list timer manager: a table of software timers with a delta-ordered
// expiry list. pulse start with an op while busy is low; each result beat
// appears on the result ports for exactly one cycle with strobe high, and
// last marks the final beat of an item. the receiver cannot stall, so it
// must take every strobe beat. create, delete, start and stop give one reply
// beat each; a tick gives one notice beat per expired timer, or none.
// a two-entry command queue lets up to two items wait while one runs;
// busy is high while that queue is full. items are handled by the sequencer
// walking the slot and list memories: create scans the slot table for a
// free slot, a lookup scans it for the owner and handle, a removal finds
// the entry in the list and shifts the list down, an insertion passes
// entries to its position and shifts the rest up, and a tick shifts the list
// once per expired timer, then gives each notice beat and reinsertion.
module delta_list_timer_manager (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic [15:0]        owner,
  input  logic [15:0]        handle,
  input  logic signed [31:0] period,
  input  logic               one_shot,
  output logic               strobe,
  output logic               kind,
  output logic [1:0]         status,
  output logic [15:0]        result_id,
  output logic [15:0]        result_owner,
  output logic               last
);

  // front to back command path
  logic           q_valid;
  logic           pop;
  dltm_pkg::cmd_t q_cmd;

  // front: decode, timeout check, drop of unknown ops, queue
  dltm_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .owner(owner), .handle(handle), .period(period),
    .one_shot(one_shot), .pop(pop), .q_valid(q_valid), .q_cmd(q_cmd)
  );

  // back: slot table, delta list and expiry sequencing
  dltm_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_cmd(q_cmd), .pop(pop),
    .strobe(strobe), .kind(kind), .status(status), .result_id(result_id),
    .result_owner(result_owner), .last(last)
  );

endmodule

@@ sim/delta_list_timer_manager_test.sv @@
`timescale 1ns / 100ps

// self-checking bench for the delta list timer manager
module delta_list_timer_manager_test;
  import dltm_pkg::*;

  localparam int IDLE_LIMIT  = 200000; // cycles with no beat either way
  localparam int SETTLE_CYC  = 3000;   // a tick with no notice may still be walking
  localparam int RANDOM_ITEMS = 270;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] owner;
    logic [15:0] handle;
    logic [31:0] period;
    logic        one_shot;
  } timer_cmd_t;

  typedef struct {
    logic        kind;
    logic [1:0]  status;
    logic [15:0] id;
    logic [15:0] owner;
    logic        last;
  } timer_beat_t;

  typedef struct {
    timer_cmd_t  cmd;
    bit          typed;  // expected reply written in by hand
    timer_beat_t reply;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  op;
  logic [15:0] owner;
  logic [15:0] handle;
  logic signed [31:0] period;
  logic        one_shot;
  logic        strobe;
  logic        kind;
  logic [1:0]  status;
  logic [15:0] result_id;
  logic [15:0] result_owner;
  logic        last;

  delta_list_timer_manager uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .owner(owner), .handle(handle), .period(period), .one_shot(one_shot),
    .strobe(strobe), .kind(kind), .status(status), .result_id(result_id),
    .result_owner(result_owner), .last(last)
  );

  // shadow of the timer table and the expiry list
  bit          tmr_used    [TIMER_SLOTS];
  logic [15:0] tmr_ident   [TIMER_SLOTS];
  logic [15:0] tmr_owner   [TIMER_SLOTS];
  logic [30:0] tmr_period  [TIMER_SLOTS];
  bit          tmr_single  [TIMER_SLOTS];
  bit          tmr_running [TIMER_SLOTS];
  int          dl_slot     [TIMER_SLOTS];
  logic [30:0] dl_delta    [TIMER_SLOTS];
  int          dl_count;
  logic [15:0] id_seq;

  timer_beat_t   expected_beats[$]; // beats still owed by the block
  timer_beat_t   step_beats[$];     // beats caused by the item just taken
  directed_row_t directed_rows[$];
  int  fail_count;
  int  idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- shadow list

  // drop one list position, closing the gap
  function automatic void dl_drop(int pos);
    for (int i = pos; i < dl_count - 1; i++) begin
      dl_slot[i]  = dl_slot[i + 1];
      dl_delta[i] = dl_delta[i + 1];
    end
    dl_count--;
  endfunction

  // sorted insert: equal expiry times keep their order of arrival
  function automatic void dl_insert(int s);
    logic [30:0] remain;
    int pos;
    remain = tmr_period[s];
    pos = 0;
    while (pos < dl_count && remain >= dl_delta[pos]) begin
      remain -= dl_delta[pos];
      pos++;
    end
    if (pos < dl_count) begin
      dl_delta[pos] -= remain;
      for (int i = dl_count; i > pos; i--) begin
        dl_slot[i]  = dl_slot[i - 1];
        dl_delta[i] = dl_delta[i - 1];
      end
    end
    dl_slot[pos]  = s;
    dl_delta[pos] = remain;
    dl_count++;
    tmr_running[s] = 1'b1;
  endfunction

  // take a timer out, its delta passes to the entry behind it
  function automatic void dl_remove(int s);
    for (int pos = 0; pos < dl_count; pos++) begin
      if (dl_slot[pos] == s) begin
        if (pos + 1 < dl_count) dl_delta[pos + 1] += dl_delta[pos];
        dl_drop(pos);
        break;
      end
    end
    tmr_running[s] = 1'b0;
  endfunction

  function automatic void push_reply(logic [1:0] st, logic [15:0] id);
    timer_beat_t b;
    b.kind = KIND_REPLY; b.status = st; b.id = id; b.owner = '0; b.last = 1'b1;
    step_beats.push_back(b);
  endfunction

  // work out the beats that one accepted command causes, and update the shadow
  function automatic void timer_table_step(timer_cmd_t c);
    int s;
    int due[$];
    timer_beat_t b;
    step_beats.delete();
    s = -1;
    if (c.op == OP_CREATE) begin
      if (c.period == 0 || c.period[31]) begin
        push_reply(ST_BAD_TIMEOUT, '0);
        return;
      end
      for (int i = 0; i < TIMER_SLOTS; i++)
        if (!tmr_used[i] && s < 0) s = i;
      if (s < 0) begin
        push_reply(ST_FULL, '0);
        return;
      end
      id_seq++;
      tmr_used[s]    = 1'b1;
      tmr_ident[s]   = id_seq;
      tmr_owner[s]   = c.owner;
      tmr_period[s]  = c.period[30:0];
      tmr_single[s]  = c.one_shot;
      tmr_running[s] = 1'b0;
      push_reply(ST_OK, id_seq);
    end else if (c.op == OP_DELETE || c.op == OP_START || c.op == OP_STOP) begin
      for (int i = 0; i < TIMER_SLOTS; i++)
        if (s < 0 && tmr_used[i] && tmr_owner[i] == c.owner && tmr_ident[i] == c.handle)
          s = i;
      if (s < 0) begin
        push_reply(ST_NOT_FOUND, '0);
        return;
      end
      if (c.op == OP_START) begin
        if (!tmr_running[s]) dl_insert(s);
      end else begin
        if (tmr_running[s]) dl_remove(s);
        if (c.op == OP_DELETE) tmr_used[s] = 1'b0;
      end
      push_reply(ST_OK, '0);
    end else if (c.op == OP_TICK) begin
      if (dl_count == 0) return;
      if (dl_delta[0] > 0) dl_delta[0]--;
      while (dl_count > 0 && dl_delta[0] == 0) begin
        due.push_back(dl_slot[0]);
        tmr_running[dl_slot[0]] = 1'b0;
        dl_drop(0);
      end
      // notices in list order, periodic ones go back in the same order
      foreach (due[i]) begin
        b.kind = KIND_NOTICE; b.status = ST_OK;
        b.id = tmr_ident[due[i]]; b.owner = tmr_owner[due[i]];
        b.last = (i == due.size() - 1);
        step_beats.push_back(b);
        if (!tmr_single[due[i]]) dl_insert(due[i]);
      end
    end
    // ops above tick are ignored by the block
  endfunction

  // ---------------------------------------------------------------- driving

  // present one command after a random gap and hold it until taken
  task automatic send_cmd(timer_cmd_t c, bit typed, timer_beat_t reply);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0; // runs of back-to-back beats
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    op       <= c.op;
    owner    <= c.owner;
    handle   <= c.handle;
    period   <= c.period;
    one_shot <= c.one_shot;
    do @(posedge clk); while (busy);
    timer_table_step(c);
    if (typed) begin
      step_beats.delete();
      step_beats.push_back(reply);
    end
    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
  endtask

  function automatic directed_row_t mk_row(logic [2:0] o, logic [15:0] ow, logic [15:0] h,
                                          logic [31:0] p, logic os, bit typed,
                                          logic [1:0] st, logic [15:0] id);
    directed_row_t r;
    r.cmd.op = o; r.cmd.owner = ow; r.cmd.handle = h; r.cmd.period = p; r.cmd.one_shot = os;
    r.typed = typed;
    r.reply.kind = KIND_REPLY; r.reply.status = st; r.reply.id = id;
    r.reply.owner = '0; r.reply.last = 1'b1;
    return r;
  endfunction

  // pick a live timer most of the time, a stray owner and id otherwise
  function automatic timer_cmd_t pick_target(logic [2:0] o);
    timer_cmd_t c;
    int live[$];
    int k;
    c.op = o; c.period = $urandom; c.one_shot = $urandom_range(0, 1);
    c.owner = $urandom; c.handle = $urandom;
    for (int i = 0; i < TIMER_SLOTS; i++) if (tmr_used[i]) live.push_back(i);
    if (live.size() > 0 && $urandom_range(0, 9) != 0) begin
      k = live[$urandom_range(0, live.size() - 1)];
      c.owner = tmr_owner[k]; c.handle = tmr_ident[k];
    end
    return c;
  endfunction

  function automatic logic [31:0] rand_period();
    case ($urandom_range(0, 19))
      0:       return 32'd0;
      1:       return 32'h8000_0000 | $urandom;        // negative
      2:       return {1'b0, 31'($urandom)};           // far in the future
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  initial begin
    timer_cmd_t  c;
    timer_beat_t none;
    int used_now;
    int pick;

    rst = 1'b1; start = 1'b0; op = '0; owner = '0; handle = '0; period = '0; one_shot = 1'b0;
    fail_count = 0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      tmr_used[i] = 1'b0; tmr_running[i] = 1'b0;
    end
    dl_count = 0;
    id_seq = '0;
    none = '{default: '0};

    // directed: extremes, each op, the corner cases
    directed_rows.push_back(mk_row(OP_TICK,   16'h0000, 16'h0000, 32'd0, 1'b0, 0, ST_OK, 0));
    directed_rows.push_back(mk_row(OP_CREATE, 16'h0000, 16'h0000, 32'd0, 1'b0, 1,
                                   ST_BAD_TIMEOUT, 0));
    directed_rows.push_back(mk_row(OP_CREATE, 16'h0001, 16'h0000, 32'h8000_0000, 1'b1, 1,
                                   ST_BAD_TIMEOUT, 0));
    directed_rows.push_back(mk_row(OP_CREATE, 16'hFFFF, 16'hFFFF, 32'd1, 1'b1, 1, ST_OK, 1));
    directed_rows.push_back(mk_row(OP_CREATE, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 1'b0, 1,
                                   ST_OK, 2));
    directed_rows.push_back(mk_row(OP_DELETE, 16'h0005, 16'hFFFF, 32'd0, 1'b0, 1,
                                   ST_NOT_FOUND, 0));
    directed_rows.push_back(mk_row(OP_START,  16'hFFFF, 16'h0001, 32'd0, 1'b0, 1, ST_OK, 0));
    // start while already running
    directed_rows.push_back(mk_row(OP_START,  16'hFFFF, 16'h0001, 32'd0, 1'b0, 1, ST_OK, 0));
    directed_rows.push_back(mk_row(OP_TICK,   16'h0000, 16'h0000, 32'd0, 1'b0, 0, ST_OK, 0));
    directed_rows.push_back(mk_row(OP_CREATE, 16'h0003, 16'h0000, 32'd2, 1'b0, 1, ST_OK, 3));
    directed_rows.push_back(mk_row(OP_CREATE, 16'h0003, 16'h0000, 32'd2, 1'b0, 1, ST_OK, 4));
    directed_rows.push_back(mk_row(OP_START,  16'h0003, 16'h0003, 32'd0, 1'b0, 0, ST_OK, 0));
    directed_rows.push_back(mk_row(OP_START,  16'h0003, 16'h0004, 32'd0, 1'b0, 0, ST_OK, 0));
    directed_rows.push_back(mk_row(OP_START,  16'h0000, 16'h0002, 32'd0, 1'b0, 0, ST_OK, 0));
    // equal expiry times: two notices in one tick
    directed_rows.push_back(mk_row(OP_TICK,   16'h0000, 16'h0000, 32'd0, 1'b0, 0, ST_OK, 0));
    directed_rows.push_back(mk_row(OP_TICK,   16'h0000, 16'h0000, 32'd0, 1'b0, 0, ST_OK, 0));
    directed_rows.push_back(mk_row(OP_STOP,   16'h0003, 16'h0003, 32'd0, 1'b0, 0, ST_OK, 0));
    // stop while stopped
    directed_rows.push_back(mk_row(OP_STOP,   16'h0003, 16'h0003, 32'd0, 1'b0, 0, ST_OK, 0));
    directed_rows.push_back(mk_row(OP_TICK,   16'h0000, 16'h0000, 32'd0, 1'b0, 0, ST_OK, 0));
    // unknown codes are swallowed
    directed_rows.push_back(mk_row(3'd5, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 0, ST_OK, 0));
    directed_rows.push_back(mk_row(3'd7, 16'h0000, 16'h0000, 32'd5, 1'b0, 0, ST_OK, 0));
    // delete of a running timer
    directed_rows.push_back(mk_row(OP_DELETE, 16'h0000, 16'h0002, 32'd0, 1'b0, 1, ST_OK, 0));
    directed_rows.push_back(mk_row(OP_DELETE, 16'h0003, 16'h0004, 32'd0, 1'b0, 0, ST_OK, 0));
    directed_rows.push_back(mk_row(OP_DELETE, 16'hFFFF, 16'h0001, 32'd0, 1'b0, 1, ST_OK, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_cmd(directed_rows[i].cmd, directed_rows[i].typed,
                                        directed_rows[i].reply);

    // fill the table to the brim, then knock on it twice more
    used_now = 0;
    for (int i = 0; i < TIMER_SLOTS; i++) if (tmr_used[i]) used_now++;
    repeat (TIMER_SLOTS - used_now + 2) begin
      c.op = OP_CREATE; c.owner = $urandom; c.handle = $urandom;
      c.period = $urandom_range(1, 6); c.one_shot = $urandom_range(0, 1);
      send_cmd(c, 0, none);
    end

    // mixed traffic, mostly hitting live timers
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // at least once let the block drain completely
      if (n == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        c.op = OP_CREATE; c.owner = $urandom; c.handle = $urandom;
        c.period = rand_period(); c.one_shot = $urandom_range(0, 1);
      end else if (pick < 33) c = pick_target(OP_DELETE);
      else if (pick < 58)     c = pick_target(OP_START);
      else if (pick < 66)     c = pick_target(OP_STOP);
      else if (pick < 96) begin
        c = pick_target(OP_TICK);
      end else begin
        c = pick_target(3'($urandom_range(5, 7)));
      end
      send_cmd(c, 0, none);
    end
    start <= 1'b0;

    // drain, then give any silent tick time to finish
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0 && expected_beats.size() == 0)
      $display("delta_list_timer_manager test passed");
    else
      $display("delta_list_timer_manager test failed");
    $finish;
  end

  // ---------------------------------------------------------------- checking

  // every strobe beat is matched against the oldest owed beat
  always @(posedge clk) begin
    timer_beat_t want;
    if (!rst && strobe) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: kind %0d status %0d id %0h owner %0h", kind, status,
               result_id, result_owner);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind); fail_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status); fail_count++;
        end
        if (result_id !== want.id) begin
          $error("result_id: expected %0h, got %0h", want.id, result_id); fail_count++;
        end
        if (result_owner !== want.owner) begin
          $error("result_owner: expected %0h, got %0h", want.owner, result_owner);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last); fail_count++;
        end
      end
    end
  end

  // watchdog on stretches with no beat in either direction
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("delta_list_timer_manager test failed");
      $finish;
    end
  end

endmodule
